/* src/charlieplex_seven_segment_terminal_defines.svh */
// Assertion macros shared by the charlieplex terminal RTL.
`ifndef CHARLIEPLEX_SEVEN_SEGMENT_TERMINAL_DEFINES_SVH
`define CHARLIEPLEX_SEVEN_SEGMENT_TERMINAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSST_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("charlieplex terminal assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("charlieplex terminal assertion failed");

`endif

/* src/csst_pkg.sv */
// Types, constants and glyph tables of the charlieplex seven-segment terminal.
`timescale 1ns / 1ps
`default_nettype none
package csst_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } csst_in_t;

    typedef struct packed {
        logic [2:0] scan_digit;
        logic [8:0] line_output_enable;
        logic [8:0] line_level_high;
    } csst_out_t;

    localparam logic       REQ_BYTE     = 1'b0;
    localparam logic       REQ_TICK     = 1'b1;

    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] DOT_BIT      = 8'h80;
    localparam logic [7:0] GLYPH_MASK   = 8'h7F;
    localparam logic [6:0] LAST_GLYPH   = 7'd52;
    localparam logic [6:0] BLANK_GLYPH  = 7'd53;
    localparam logic [6:0] HYPHEN_GLYPH = 7'd37;
    localparam logic [6:0] ALPHA_BASE   = 7'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd53;

    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;

    localparam logic [7:0] CMD_LOCATE   = 8'h4C;
    localparam logic [7:0] CMD_CLEAR    = 8'h43;
    localparam logic [7:0] CMD_SHL      = 8'h3C;
    localparam logic [7:0] CMD_SHR      = 8'h3E;
    localparam logic [7:0] CMD_ROL      = 8'h5B;
    localparam logic [7:0] CMD_ROR      = 8'h5D;

    // Parser states, one-hot.
    typedef enum logic [3:0] {
        MODE_TEXT    = 4'b0001,
        MODE_ESC     = 4'b0010,
        MODE_LOCPOS  = 4'b0100,
        MODE_LOCCHAR = 4'b1000
    } csst_mode_t;

    // Returns {hit, glyph}; hit is set for a supported character other than the dot.
    function automatic logic [7:0] glyph_of(input logic [7:0] c);
        logic [7:0] res;
        res = 8'h00;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            res = {1'b1, 7'(c - CHAR_DIGIT_0)};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            res = {1'b1, 7'(c - CHAR_LOWER_A) + ALPHA_BASE};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            res = {1'b1, 7'(c - CHAR_UPPER_A) + ALPHA_BASE};
        end else if (c == CHAR_HYPHEN) begin
            res = {1'b1, HYPHEN_GLYPH};
        end else if (c == CHAR_SPACE) begin
            res = {1'b1, BLANK_GLYPH};
        end
        return res;
    endfunction

    // Segment pattern of a glyph; bit 7 is the dot. Glyphs above the last one show blank.
    function automatic logic [7:0] glyph_segments(input logic [6:0] g);
        logic [7:0] s;
        case (g)
            7'd0:  s = 8'h3F;  7'd1:  s = 8'h06;  7'd2:  s = 8'h5B;  7'd3:  s = 8'h4F;
            7'd4:  s = 8'h66;  7'd5:  s = 8'h6D;  7'd6:  s = 8'h7D;  7'd7:  s = 8'h07;
            7'd8:  s = 8'h7F;  7'd9:  s = 8'h6F;  7'd10: s = 8'h5F;  7'd11: s = 8'h7C;
            7'd12: s = 8'h58;  7'd13: s = 8'h5E;  7'd14: s = 8'h7B;  7'd15: s = 8'h71;
            7'd16: s = 8'h3D;  7'd17: s = 8'h74;  7'd18: s = 8'h04;  7'd19: s = 8'h1E;
            7'd20: s = 8'h75;  7'd21: s = 8'h38;  7'd22: s = 8'h37;  7'd23: s = 8'h54;
            7'd24: s = 8'h5C;  7'd25: s = 8'h73;  7'd26: s = 8'h67;  7'd27: s = 8'h50;
            7'd28: s = 8'h6C;  7'd29: s = 8'h78;  7'd30: s = 8'h1C;  7'd31: s = 8'h3E;
            7'd32: s = 8'h7E;  7'd33: s = 8'h76;  7'd34: s = 8'h66;  7'd35: s = 8'h1B;
            7'd36: s = 8'h63;  7'd37: s = 8'h40;  7'd38: s = 8'h46;  7'd39: s = 8'h70;
            7'd40: s = 8'h52;  7'd41: s = 8'h64;  7'd42: s = 8'h01;  7'd43: s = 8'h02;
            7'd44: s = 8'h04;  7'd45: s = 8'h08;  7'd46: s = 8'h10;  7'd47: s = 8'h20;
            7'd48: s = 8'h80;  7'd49: s = 8'h0F;  7'd50: s = 8'h39;  7'd51: s = 8'h41;
            7'd52: s = 8'h48;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* src/charlieplex_seven_segment_terminal.sv */
// Top level of the charlieplexed eight-digit seven-segment terminal.
//
// Usage: the input channel (s_valid, s_ready, s_data) carries one transaction per
// received byte or per scan tick, selected by s_data.req_type. A byte transaction
// updates the eight-digit glyph buffer and the escape-sequence parser and yields no
// result. A tick transaction yields exactly one result transaction on the output
// channel (m_valid, m_ready, m_data): the scanned digit and its nine-line drive
// pattern (output enables and high levels), after which the scan moves on.
// Latency: a tick result is presented in the cycle after the tick is accepted.
// Throughput: one transaction per cycle unless a held result stalls it, bytes and ticks
// alike; all decoding is a single combinational pass from the state registers into
// the result register. Stall: while a result waits and m_ready is low, s_ready is low;
// the result register holds its transaction until it is taken. When m_ready is high a
// new transaction is accepted in the same cycle the held result leaves.
// Reset (aresetn low, synchronous): all digits go blank, the parser returns to
// text mode, the stored locate byte and the scan position clear, and no result
// is pending.
`timescale 1ns / 1ps
`default_nettype none
`include "charlieplex_seven_segment_terminal_defines.svh"
module charlieplex_seven_segment_terminal (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire csst_pkg::csst_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output csst_pkg::csst_out_t       m_data
);
    import csst_pkg::*;

    // Glyph buffer: digit 0 is leftmost, digit 7 rightmost. Bit 7 of a code is the dot.
    logic [7:0] codes_reg [8];
    logic [7:0] codes_next [8];
    csst_mode_t mode_reg, mode_next;
    logic [7:0] locate_reg, locate_next;
    logic [2:0] scan_reg, scan_next;

    logic      m_valid_reg, m_valid_next;
    csst_out_t m_data_reg, m_data_next;

    logic       accept;
    logic       accept_tick;
    logic       accept_byte;
    logic [7:0] c;
    logic [7:0] glyph_hit;
    logic [2:0] locate_pos;
    logic       locate_valid;

    // Tick decode signals.
    logic [7:0] scan_code;
    logic [6:0] scan_glyph;
    logic [7:0] scan_seg;
    logic [8:0] line_enable;
    logic [8:0] line_high;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign accept_tick = accept && (s_data.req_type == REQ_TICK);
    assign accept_byte = accept && (s_data.req_type == REQ_BYTE);
    assign c           = s_data.rx_byte;
    assign glyph_hit   = glyph_of(c);

    // Locate position p maps to digit 7-p, which is the complement of its low bits.
    assign locate_valid = (locate_reg >= CHAR_DIGIT_0) && (locate_reg <= CHAR_DIGIT_7);
    assign locate_pos   = ~locate_reg[2:0];

    // Byte parser and buffer update.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            codes_next[i] = codes_reg[i];
        end
        mode_next   = mode_reg;
        locate_next = locate_reg;
        if (accept_byte) begin
            unique case (mode_reg)
                MODE_TEXT: begin
                    if (c == ESC_BYTE) begin
                        mode_next = MODE_ESC;
                    end else if (c == CHAR_DOT) begin
                        codes_next[7] = codes_reg[7] | DOT_BIT;
                    end else if (glyph_hit[7]) begin
                        // Scroll in at the right with the dot clear.
                        for (int i = 0; i < 7; i++) begin
                            codes_next[i] = codes_reg[i + 1];
                        end
                        codes_next[7] = {1'b0, glyph_hit[6:0]};
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_TEXT;
                    case (c) inside
                        CMD_LOCATE: mode_next = MODE_LOCPOS;
                        CMD_CLEAR: begin
                            for (int i = 0; i < 8; i++) begin
                                codes_next[i] = BLANK_CODE;
                            end
                        end
                        CMD_SHL, CMD_ROL: begin
                            for (int i = 0; i < 7; i++) begin
                                codes_next[i] = codes_reg[i + 1];
                            end
                            codes_next[7] = (c == CMD_SHL) ? BLANK_CODE : codes_reg[0];
                        end
                        CMD_SHR, CMD_ROR: begin
                            for (int i = 1; i < 8; i++) begin
                                codes_next[i] = codes_reg[i - 1];
                            end
                            codes_next[0] = (c == CMD_SHR) ? BLANK_CODE : codes_reg[7];
                        end
                        default: begin
                            // Unknown commands, a second escape among them, are dropped.
                        end
                    endcase
                end
                MODE_LOCPOS: begin
                    locate_next = c;
                    mode_next   = MODE_LOCCHAR;
                end
                MODE_LOCCHAR: begin
                    mode_next = MODE_TEXT;
                    for (int i = 0; i < 8; i++) begin
                        if (locate_valid && (locate_pos == 3'(i))) begin
                            if (c == CHAR_DOT) begin
                                codes_next[i] = codes_reg[i] | DOT_BIT;
                            end else if (glyph_hit[7]) begin
                                codes_next[i] = {1'b0, glyph_hit[6:0]};
                            end
                        end
                    end
                end
                default: mode_next = MODE_TEXT;
            endcase
        end
    end

    // Tick decode: anode on line d+1, segment b on line b+2 unless that is the anode,
    // in which case the segment moves to line 1.
    always_comb begin
        scan_code  = codes_reg[scan_reg];
        scan_glyph = scan_code[6:0] & GLYPH_MASK[6:0];
        if (scan_glyph > LAST_GLYPH) begin
            scan_glyph = BLANK_GLYPH;
        end
        scan_seg = glyph_segments(scan_glyph) | (scan_code & DOT_BIT);
        line_high   = 9'(1) << scan_reg;
        line_enable = line_high;
        for (int b = 0; b < 8; b++) begin
            if (scan_seg[b]) begin
                if (b + 1 == int'(scan_reg)) begin
                    line_enable[0] = 1'b1;
                end else begin
                    line_enable[b + 1] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (accept_tick) begin
            scan_next                      = scan_reg + 3'd1;
            m_valid_next                   = 1'b1;
            m_data_next.scan_digit         = scan_reg;
            m_data_next.line_output_enable = line_enable;
            m_data_next.line_level_high    = line_high;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                codes_reg[i] <= BLANK_CODE;
            end
            mode_reg    <= MODE_TEXT;
            locate_reg  <= 8'h00;
            scan_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < 8; i++) begin
                codes_reg[i] <= codes_next[i];
            end
            mode_reg    <= mode_next;
            locate_reg  <= locate_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The result register carries no reset; m_valid_reg qualifies it.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A tick produces a result for the digit that was current, and the scan advances.
    `CSST_ASSERT_NEXT(a_tick_result, aclk, aresetn, accept_tick, m_valid_reg && (m_data_reg.scan_digit == $past(scan_reg)))
    `CSST_ASSERT_NEXT(a_scan_advance, aclk, aresetn, accept_tick, scan_reg == $past(scan_reg) + 3'd1)
    // Exactly one line is high, and it is driven.
    `CSST_ASSERT_NOW(a_one_anode, aclk, aresetn, m_valid_reg, ($countones(m_data_reg.line_level_high) == 1) && ((m_data_reg.line_level_high & ~m_data_reg.line_output_enable) == 9'd0))
    // A byte never touches the scan position.
    `CSST_ASSERT_NEXT(a_byte_no_scan, aclk, aresetn, accept_byte, $stable(scan_reg))

endmodule
`default_nettype wire
